@@ rtl/thti_pkg.sv @@
// Shared types and constants for the terrain height triangle interpolator
`timescale 1ns / 1ps

package thti_pkg;

  // height samples and interpolation weights
  localparam int HEIGHT_W = 16;
  localparam int FRAC_W = 16;
  localparam int WT_W = FRAC_W + 1;
  localparam logic [WT_W-1:0] FRAC_ONE = 17'h10000;

  // entries held between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // request codes on cmd
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes on the cfg channel
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd1;
  localparam logic [2:0] REG_INV_CELL   = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd3;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd4;

  // what the back does with one queue entry
  typedef enum logic [1:0] {
    K_WRITE,
    K_MISS,
    K_QUERY
  } kind_t;

  // configuration registers as seen by the front
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_cell_space;
    logic [8:0]         map_width;
    logic [8:0]         map_height;
  } cfg_regs_t;

  // packed width of one queue entry for a given store address width
  function automatic int entry_w(int addr_w);
    return $bits(kind_t) + 3 * addr_w + 2 * WT_W + HEIGHT_W;
  endfunction

endpackage

@@ rtl/thti_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps

module thti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write has priority, read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/thti_queue.sv @@
// Small request queue between the front and the back
`timescale 1ns / 1ps

module thti_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_data = slots[rd_ptr];
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/thti_front.sv @@
// Front: accepts requests, maps query positions to grid cells and classifies them
`timescale 1ns / 1ps

module thti_front
  import thti_pkg::*;
#(
  parameter int MAX_DIM = 256,
  parameter int ADDR_W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [15:0]                 write_index,
  input  logic [HEIGHT_W-1:0]         write_height,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_z,
  input  cfg_regs_t                   cfg,
  output logic                        push,
  output logic [entry_w(ADDR_W)-1:0]  push_data,
  input  logic                        full
);

  localparam int IDX_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_X,
    F_MUL_Z,
    F_CLS,
    F_PUSH
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr_p;
    logic [ADDR_W-1:0]   addr_b;
    logic [ADDR_W-1:0]   addr_c;
    logic [WT_W-1:0]     wt_b;
    logic [WT_W-1:0]     wt_c;
    logic [HEIGHT_W-1:0] wdata;
  } entry_t;

  state_t              state;
  logic signed [32:0]  dx;
  logic signed [32:0]  dz;
  logic [63:0]         prod;
  logic                ok_x;
  logic                ok_z;
  logic [IDX_W-1:0]    ix;
  logic [IDX_W-1:0]    iz;
  logic [FRAC_W-1:0]   s;
  logic [FRAC_W-1:0]   t;

  logic                accept;
  logic                wr_ok;
  logic [DIM_W-1:0]    dim_w;
  logic [DIM_W-1:0]    dim_h;
  logic [31:0]         mul_a;
  logic [63:0]         mul_full;
  logic                axis_neg;
  logic [DIM_W-1:0]    axis_dim;
  logic                axis_ok;
  logic [IDX_W-1:0]    axis_idx;
  logic [FRAC_W-1:0]   axis_frac;
  logic [IDX_W+DIM_W-1:0] row_off;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   row_w;
  logic [WT_W-1:0]     st_sum;
  logic                lower;
  entry_t              q_entry;
  entry_t              w_entry;

  // handshake
  assign busy   = (state != F_IDLE) || full;
  assign accept = start && !busy;
  assign wr_ok  = (32'(write_index) < 32'(DEPTH));

  // dimensions saturate at MAX_DIM, the side length of the store
  assign dim_w = (32'(cfg.map_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg.map_width);
  assign dim_h = (32'(cfg.map_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                      : DIM_W'(cfg.map_height);

  // shared scale multiplier, x offset first then z offset
  assign mul_a    = (state == F_MUL_X) ? dx[31:0] : dz[31:0];
  assign mul_full = 64'(mul_a) * 64'(cfg.inv_cell_space);

  // cell index and fraction for the axis whose product sits in prod
  always_comb begin
    axis_neg  = (state == F_MUL_Z) ? dx[32] : dz[32];
    axis_dim  = (state == F_MUL_Z) ? dim_w : dim_h;
    axis_ok   = 1'b0;
    axis_idx  = '0;
    axis_frac = '0;
    if (axis_dim < DIM_W'(2)) begin
      axis_ok = 1'b0;
    end else if (cfg.inv_cell_space == '0) begin
      axis_ok = 1'b1;
    end else if (!axis_neg && (prod[63:32] < 32'(axis_dim) - 32'd1)) begin
      axis_ok   = 1'b1;
      axis_idx  = prod[32 +: IDX_W];
      axis_frac = prod[31:16];
    end
  end

  // corner addresses, triangle choice and weights
  always_comb begin
    row_off = iz * dim_w;
    base    = ADDR_W'(row_off) + ADDR_W'(ix);
    row_w   = ADDR_W'(dim_w);
    st_sum  = {1'b0, s} + {1'b0, t};
    lower   = (st_sum <= FRAC_ONE);

    q_entry.kind   = (ok_x && ok_z) ? K_QUERY : K_MISS;
    q_entry.addr_p = lower ? base : base + row_w + ADDR_W'(1);
    q_entry.addr_b = base + ADDR_W'(1);
    q_entry.addr_c = base + row_w;
    q_entry.wt_b   = lower ? {1'b0, s} : FRAC_ONE - {1'b0, t};
    q_entry.wt_c   = lower ? {1'b0, t} : FRAC_ONE - {1'b0, s};
    q_entry.wdata  = '0;

    w_entry.kind   = K_WRITE;
    w_entry.addr_p = ADDR_W'(write_index);
    w_entry.addr_b = '0;
    w_entry.addr_c = '0;
    w_entry.wt_b   = '0;
    w_entry.wt_c   = '0;
    w_entry.wdata  = write_height;
  end

  // writes go straight into the queue, queries after classification
  assign push      = (accept && (cmd == CMD_WRITE) && wr_ok) || ((state == F_PUSH) && !full);
  assign push_data = (state == F_PUSH) ? q_entry : w_entry;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (cmd == CMD_QUERY)) begin
            dx    <= $signed({pos_x[31], pos_x}) - $signed({cfg.origin_x[31], cfg.origin_x});
            dz    <= $signed({cfg.origin_z[31], cfg.origin_z}) - $signed({pos_z[31], pos_z});
            state <= F_MUL_X;
          end
        end
        F_MUL_X: begin
          prod  <= mul_full;
          state <= F_MUL_Z;
        end
        F_MUL_Z: begin
          prod  <= mul_full;
          ok_x  <= axis_ok;
          ix    <= axis_idx;
          s     <= axis_frac;
          state <= F_CLS;
        end
        F_CLS: begin
          ok_z  <= axis_ok;
          iz    <= axis_idx;
          t     <= axis_frac;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/thti_back.sv @@
// Back: height store, corner reads and triangle interpolation
`timescale 1ns / 1ps

module thti_back
  import thti_pkg::*;
#(
  parameter int ADDR_W = 16,
  parameter int DEPTH = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  output logic                        pop,
  input  logic [entry_w(ADDR_W)-1:0]  pop_data,
  output logic                        done,
  output logic [HEIGHT_W-1:0]         height,
  output logic                        in_range
);

  localparam int PROD_W = 35;
  localparam int SUM_W = 36;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD_B,
    B_RD_C,
    B_MUL_C,
    B_SUM
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr_p;
    logic [ADDR_W-1:0]   addr_b;
    logic [ADDR_W-1:0]   addr_c;
    logic [WT_W-1:0]     wt_b;
    logic [WT_W-1:0]     wt_c;
    logic [HEIGHT_W-1:0] wdata;
  } entry_t;

  state_t                    state;
  entry_t                    cur;
  entry_t                    head;
  logic [HEIGHT_W-1:0]       p;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic [SUM_W-1:0]          acc;

  logic                      ram_we;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_addr;
  logic [HEIGHT_W-1:0]       rdata;
  logic [WT_W-1:0]           wt_sel;
  logic signed [HEIGHT_W:0]  diff;
  logic signed [PROD_W-1:0]  mul_full;
  logic [SUM_W-1:0]          sum;
  logic [HEIGHT_W-1:0]       res;

  assign head = pop_data;
  assign pop  = (state == B_IDLE) && !empty;

  // store port: write or corner read
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = head.addr_p;
    unique case (state)
      B_IDLE: begin
        ram_we = pop && (head.kind == K_WRITE);
        ram_re = pop && (head.kind == K_QUERY);
      end
      B_RD_B: begin
        ram_re   = 1'b1;
        ram_addr = cur.addr_b;
      end
      B_RD_C: begin
        ram_re   = 1'b1;
        ram_addr = cur.addr_c;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  thti_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (head.wdata),
    .rdata (rdata)
  );

  // weighted difference against the base corner
  assign wt_sel   = (state == B_RD_C) ? cur.wt_b : cur.wt_c;
  assign diff     = $signed({1'b0, rdata}) - $signed({1'b0, p});
  assign mul_full = $signed({1'b0, wt_sel}) * diff;

  // final sum, floor shift and clamp
  always_comb begin
    sum = acc + {{(SUM_W - PROD_W){prod_c[PROD_W-1]}}, prod_c};
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:32]) begin
      res = '1;
    end else begin
      res = sum[31:16];
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              K_MISS: begin
                done     <= 1'b1;
                height   <= '0;
                in_range <= 1'b0;
              end
              K_QUERY: begin
                cur   <= head;
                state <= B_RD_B;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_RD_B: begin
          p     <= rdata;
          state <= B_RD_C;
        end
        B_RD_C: begin
          prod_b <= mul_full;
          state  <= B_MUL_C;
        end
        B_MUL_C: begin
          prod_c <= mul_full;
          acc    <= {{(SUM_W - 32){1'b0}}, p, 16'b0}
                    + {{(SUM_W - PROD_W){prod_b[PROD_W-1]}}, prod_b};
          state  <= B_SUM;
        end
        B_SUM: begin
          done     <= 1'b1;
          height   <= res;
          in_range <= 1'b1;
          state    <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/terrain_height_triangle_interp.sv @@
// Top level of the terrain height triangle interpolator
`timescale 1ns / 1ps
//
// A request is taken at a clock edge where start is high and busy is low.
// cmd low writes write_height into the sample at write_index (addresses at or
// beyond MAX_DIM*MAX_DIM are dropped); cmd high queries the height at pos_x,
// pos_z. Each query gives one result: done is high for exactly one cycle with
// height and in_range valid in that cycle. Writes give no result.
// Writes are taken one per cycle while busy is low. A query keeps busy high
// after it is taken while the front runs both axes through its one shared
// 32x32 multiplier and classifies the cell; the back does three reads from
// the single-port height store and two weighted differences per query,
// taking no new queue entry until that query's result is out. A query
// outside the grid gives done sooner than one in the grid. busy also stays
// high while the four-entry request queue is full. Registers are written over
// the cfg channel (cfg_ready is always high); the user must write them only
// while no request is in flight, and the block does not enforce this. Reset
// clears the queue, the sequencers and the registers to their defaults; store
// contents are undefined until written. The receiver cannot stall results.

module terrain_height_triangle_interp
  import thti_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [15:0]          write_index,
  input  logic [HEIGHT_W-1:0]  write_height,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_z,
  output logic                 done,
  output logic [HEIGHT_W-1:0]  height,
  output logic                 in_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ENTRY_W = entry_w(ADDR_W);

  cfg_regs_t          cfg;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] pop_data;
  logic               full;
  logic               empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x       <= '0;
      cfg.origin_z       <= '0;
      cfg.inv_cell_space <= 32'h0001_0000;
      cfg.map_width      <= 9'd256;
      cfg.map_height     <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   cfg.origin_x       <= cfg_data;
        REG_ORIGIN_Z:   cfg.origin_z       <= cfg_data;
        REG_INV_CELL:   cfg.inv_cell_space <= cfg_data;
        REG_MAP_WIDTH:  cfg.map_width      <= cfg_data[8:0];
        REG_MAP_HEIGHT: cfg.map_height     <= cfg_data[8:0];
        default:        cfg.map_height     <= cfg.map_height;
      endcase
    end
  end

  thti_front #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .write_index  (write_index),
    .write_height (write_height),
    .pos_x        (pos_x),
    .pos_z        (pos_z),
    .cfg          (cfg),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  thti_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  thti_back #(
    .ADDR_W (ADDR_W),
    .DEPTH  (STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .pop_data (pop_data),
    .done     (done),
    .height   (height),
    .in_range (in_range)
  );

endmodule
